>>> src/splitmix64_bounded_random_defines.svh
// ----------------------------------------------------------------------------
// splitmix64_bounded_random assertion macros
// Clocked, reset-qualified assertion wrappers; ASSERT_OFF removes them all.
// ----------------------------------------------------------------------------
`ifndef SPLITMIX64_BOUNDED_RANDOM_DEFINES_SVH
`define SPLITMIX64_BOUNDED_RANDOM_DEFINES_SVH

`ifndef ASSERT_OFF
// plain property, sampled on clk_i, off while rst_ni is low
`define SMBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication form
`define SMBR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SMBR_ASSERT(lbl, prop, msg)
`define SMBR_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

>>> src/smbr_pkg.sv
// ----------------------------------------------------------------------------
// smbr_pkg
// Shared constants and interface structs of the bounded splitmix64 generator.
// ----------------------------------------------------------------------------
package smbr_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = WordW / 2;

  localparam logic [WordW-1:0] Gamma   = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] MixA    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WordW-1:0] MixB    = 64'h94D0_49BB_1331_11EB;
  localparam logic [WordW-1:0] AllOnes = '1;

  localparam int unsigned ShiftA = 30;
  localparam int unsigned ShiftB = 27;
  localparam int unsigned ShiftC = 31;

  // request kinds
  localparam logic [1:0] KIND_RAW     = 2'd0;
  localparam logic [1:0] KIND_BOUNDED = 2'd1;
  localparam logic [1:0] KIND_ID      = 2'd2;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] state;
  } mix_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WordW-1:0] value;
  } mix_rsp_t;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WordW-1:0] rem;
  } div_rsp_t;

endpackage

>>> src/smbr_mixer.sv
// ----------------------------------------------------------------------------
// smbr_mixer
// splitmix64 output mix on one shared 32x32 multiplier, three partial
// products per 64-bit multiply, two multiplies per draw.
// ----------------------------------------------------------------------------
module smbr_mixer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smbr_pkg::mix_req_t  req_i,
  output smbr_pkg::mix_rsp_t  rsp_o
);
  import smbr_pkg::*;

  localparam logic [1:0] LastPart = 2'd2;

  logic             busy_q, done_q, phase_q;
  logic [1:0]       cnt_q;
  logic [WordW-1:0] x_q, acc_q, res_q;

  logic [WordW-1:0] coef, prod, term, acc_sum;
  logic [HalfW-1:0] a_op, b_op;

  always_comb begin
    coef    = phase_q ? MixB : MixA;
    a_op    = (cnt_q == LastPart) ? x_q[WordW-1:HalfW] : x_q[HalfW-1:0];
    b_op    = (cnt_q == 2'd1) ? coef[WordW-1:HalfW] : coef[HalfW-1:0];
    prod    = a_op * b_op;
    // cross terms land in the upper half only
    term    = (cnt_q == 2'd0) ? prod : {prod[HalfW-1:0], {HalfW{1'b0}}};
    acc_sum = acc_q + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        cnt_q   <= '0;
      end else if (busy_q) begin
        if (cnt_q == LastPart) begin
          cnt_q   <= '0;
          phase_q <= 1'b1;
          if (phase_q) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end else begin
          cnt_q <= cnt_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= req_i.state ^ (req_i.state >> ShiftA);
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == LastPart) begin
        acc_q <= '0;
        if (phase_q) res_q <= acc_sum ^ (acc_sum >> ShiftC);
        else         x_q   <= acc_sum ^ (acc_sum >> ShiftB);
      end else begin
        acc_q <= acc_sum;
      end
    end
  end

  assign rsp_o.busy  = busy_q;
  assign rsp_o.done  = done_q;
  assign rsp_o.value = res_q;

endmodule

>>> src/smbr_divider.sv
// ----------------------------------------------------------------------------
// smbr_divider
// Restoring radix-2 divider, one quotient bit per cycle; returns remainder.
// ----------------------------------------------------------------------------
module smbr_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smbr_pkg::div_req_t  req_i,
  output smbr_pkg::div_rsp_t  rsp_o
);
  import smbr_pkg::*;

  localparam int unsigned CntW = $clog2(WordW);
  localparam logic [CntW-1:0] LastStep = CntW'(WordW - 1);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [WordW-1:0] num_q, den_q, rem_q;

  logic [WordW:0]   shifted, diff;

  always_comb begin
    shifted = {rem_q, num_q[WordW-1]};
    diff    = shifted - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[WordW-2:0], 1'b0};
      // partial remainder stays below the divisor, so it fits in one word
      rem_q <= diff[WordW] ? shifted[WordW-1:0] : diff[WordW-1:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> src/splitmix64_bounded_random.sv
// ----------------------------------------------------------------------------
// splitmix64_bounded_random
// splitmix64 generator with raw, bounded and 128-bit identifier requests.
// One request is in work at a time; in_ready_o is low while it runs. A draw
// loads the mixer, then runs on its single 32x32 multiplier (three partial
// products per 64-bit multiply, two multiplies). A raw word takes one draw,
// an identifier two. A bounded request runs the one-bit-per-cycle divider
// twice (load plus 64 steps each: once for the rejection limit and once for
// the final remainder) around its draws: one draw when the first is kept and
// one more per rejected draw. A zero bound or unused kind goes to the result
// without drawing. The result sits in an output register, so the next request
// is taken while it waits. Writing the seed reloads the generator state.
// ----------------------------------------------------------------------------
`include "splitmix64_bounded_random_defines.svh"

module splitmix64_bounded_random (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        seed_we_i,
  input  logic [smbr_pkg::WordW-1:0]  seed_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  kind_i,
  input  logic [smbr_pkg::WordW-1:0]  bound_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [smbr_pkg::WordW-1:0]  low_word_o,
  output logic [smbr_pkg::WordW-1:0]  high_word_o
);
  import smbr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LIMIT  = 5'b00010,
    ST_DRAW   = 5'b00100,
    ST_REDUCE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [1:0]       kind_q, kind_d;
  logic             second_q, second_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] gen_q, gen_d;
  logic [WordW-1:0] bound_q, bound_d;
  logic [WordW-1:0] limit_q, limit_d;
  logic [WordW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [WordW-1:0] out_lo_q, out_lo_d, out_hi_q, out_hi_d;
  logic [WordW-1:0] gen_next;
  logic             draw_go, in_fire;

  mix_req_t mix_req;
  mix_rsp_t mix_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  smbr_mixer u_mixer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mix_req),
    .rsp_o  (mix_rsp)
  );

  smbr_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign gen_next   = gen_q + Gamma;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    second_d    = second_q;
    bound_d     = bound_q;
    limit_d     = limit_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_lo_d    = out_lo_q;
    out_hi_d    = out_hi_q;
    draw_go     = 1'b0;
    div_req     = '{start: 1'b0, dividend: AllOnes, divisor: bound_q};

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          kind_d   = kind_i;
          bound_d  = bound_i;
          second_d = 1'b0;
          lo_d     = '0;
          hi_d     = '0;
          case (kind_i)
            KIND_RAW, KIND_ID: begin
              draw_go = 1'b1;
              state_d = ST_DRAW;
            end
            KIND_BOUNDED: begin
              if (bound_i == '0) begin
                state_d = ST_DONE;
              end else begin
                div_req = '{start: 1'b1, dividend: AllOnes, divisor: bound_i};
                state_d = ST_LIMIT;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_LIMIT: begin
        if (div_rsp.done) begin
          limit_d = AllOnes - div_rsp.rem;
          draw_go = 1'b1;
          state_d = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (mix_rsp.done) begin
          case (kind_q)
            KIND_BOUNDED: begin
              if (mix_rsp.value >= limit_q) begin
                draw_go = 1'b1;   // rejected, draw again
              end else begin
                div_req = '{start: 1'b1, dividend: mix_rsp.value, divisor: bound_q};
                state_d = ST_REDUCE;
              end
            end
            KIND_ID: begin
              if (!second_q) begin
                hi_d     = mix_rsp.value;
                second_d = 1'b1;
                draw_go  = 1'b1;
              end else begin
                lo_d    = ((hi_q == '0) && (mix_rsp.value == '0)) ? WordW'(1)
                                                                  : mix_rsp.value;
                state_d = ST_DONE;
              end
            end
            default: begin
              lo_d    = mix_rsp.value;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_REDUCE: begin
        if (div_rsp.done) begin
          lo_d    = div_rsp.rem;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_lo_d    = lo_q;
          out_hi_d    = hi_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    mix_req.start = draw_go;
    mix_req.state = gen_next;

    gen_d = draw_go ? gen_next : gen_q;
    if (seed_we_i) gen_d = seed_wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KIND_RAW;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
      gen_q       <= '0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
      gen_q       <= gen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bound_q  <= bound_d;
    limit_q  <= limit_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    out_lo_q <= out_lo_d;
    out_hi_q <= out_hi_d;
  end

  assign out_valid_o = out_valid_q;
  assign low_word_o  = out_lo_q;
  assign high_word_o = out_hi_q;

  `SMBR_ASSERT(a_units_exclusive, !(mix_rsp.busy && div_rsp.busy),
    "mixer and divider busy together")
  `SMBR_ASSERT_IMP(a_id_nonzero, (state_q == ST_DONE) && (kind_q == KIND_ID),
    (lo_q != '0) || (hi_q != '0), "identifier word is all zero")
  `SMBR_ASSERT_IMP(a_bounded_range,
    (state_q == ST_DONE) && (kind_q == KIND_BOUNDED) && (bound_q != '0),
    lo_q < bound_q, "bounded result not below bound")
  `SMBR_ASSERT_IMP(a_draw_only_busy, draw_go,
    (state_q == ST_IDLE) || (state_q == ST_LIMIT) || (state_q == ST_DRAW),
    "draw started outside a drawing step")

endmodule

>>> test/splitmix64_bounded_random_check.sv
// ----------------------------------------------------------------------------
// splitmix64_bounded_random_check
// Watches the request, seed and result ports of the bounded splitmix64
// generator. It keeps its own generator state, predicts every result word
// when a request is taken, and compares results in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module splitmix64_bounded_random_check (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        seed_we_i,
  input  logic [smbr_pkg::WordW-1:0]  seed_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_o,
  input  logic [1:0]                  kind_i,
  input  logic [smbr_pkg::WordW-1:0]  bound_i,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [smbr_pkg::WordW-1:0]  low_word_o,
  input  logic [smbr_pkg::WordW-1:0]  high_word_o,
  output int unsigned                 fail_count,
  output int unsigned                 pending_count,
  output int unsigned                 checked_count,
  output int unsigned                 redraw_count
);
  import smbr_pkg::*;

  typedef struct {
    logic [1:0]       kind;
    logic [WordW-1:0] low_word;
    logic [WordW-1:0] high_word;
  } word_pair_t;

  word_pair_t       expected_words[$];
  logic [WordW-1:0] gen_state;

  function automatic logic [WordW-1:0] next_draw();
    logic [WordW-1:0] z;
    gen_state = gen_state + Gamma;
    z = gen_state;
    z = (z ^ (z >> ShiftA)) * MixA;
    z = (z ^ (z >> ShiftB)) * MixB;
    return z ^ (z >> ShiftC);
  endfunction

  // draws at or above the largest multiple of the bound are thrown away
  function automatic logic [WordW-1:0] draw_below(input logic [WordW-1:0] bound);
    logic [WordW-1:0] limit;
    logic [WordW-1:0] v;
    if (bound == '0) return '0;
    limit = AllOnes - (AllOnes % bound);
    v = next_draw();
    while (v >= limit) begin
      v = next_draw();
      redraw_count++;
    end
    return v % bound;
  endfunction

  function automatic word_pair_t predict_words(input logic [1:0] kind,
                                               input logic [WordW-1:0] bound);
    word_pair_t r;
    r.kind      = kind;
    r.low_word  = '0;
    r.high_word = '0;
    case (kind)
      KIND_RAW:     r.low_word = next_draw();
      KIND_BOUNDED: r.low_word = draw_below(bound);
      KIND_ID: begin
        r.high_word = next_draw();
        r.low_word  = next_draw();
        if (r.high_word == '0 && r.low_word == '0) r.low_word = 'd1;
      end
      default: ;  // unused kind: zero word, state untouched
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_pair_t want;
    if (!rst_ni) begin
      gen_state = '0;
      expected_words.delete();
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
      redraw_count  = 0;
    end else begin
      if (seed_we_i) gen_state = seed_wdata_i;
      if (in_valid_i && in_ready_o)
        expected_words.insert(expected_words.size(), predict_words(kind_i, bound_i));
      if (out_valid_o && out_ready_i) begin
        checked_count++;
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected word low %h high %h", $realtime, low_word_o,
                     high_word_o);
        end else begin
          want = expected_words.pop_front();
          if (want.low_word !== low_word_o || want.high_word !== high_word_o) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: kind %0d low exp %h got %h, high exp %h got %h", $realtime,
                       want.kind, want.low_word, low_word_o, want.high_word, high_word_o);
          end
        end
      end
      pending_count = expected_words.size();
    end
  end

endmodule

>>> test/splitmix64_bounded_random_test.sv
// ----------------------------------------------------------------------------
// splitmix64_bounded_random_test
// Drives seed loads and raw, bounded, identifier and unused-kind requests
// into the generator with random gaps and result back-pressure; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module splitmix64_bounded_random_test;
  import smbr_pkg::*;

  localparam int unsigned RandomItems = 1600;
  localparam int unsigned Phases      = 8;
  localparam int unsigned HoldCycles  = 300;
  localparam logic [1:0]  KindUnused  = 2'd3;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             seed_we_i    = 1'b0;
  logic [WordW-1:0] seed_wdata_i = '0;
  logic             in_valid_i   = 1'b0;
  logic [1:0]       kind_i       = KIND_RAW;
  logic [WordW-1:0] bound_i      = '0;
  logic             out_ready_i  = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [WordW-1:0] low_word_o;
  logic [WordW-1:0] high_word_o;

  int unsigned fail_count, pending_count, checked_count, redraw_count;
  int unsigned kind_seen[4] = '{default: 0};
  int unsigned seed_loads   = 0;
  bit          steady       = 1'b0;  // no gaps on either side
  bit          hold_req     = 1'b0;  // receiver holds off for HoldCycles

  always #1 clk_i = ~clk_i;

  splitmix64_bounded_random dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_we_i   (seed_we_i),
    .seed_wdata_i(seed_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .bound_i     (bound_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .low_word_o  (low_word_o),
    .high_word_o (high_word_o)
  );

  splitmix64_bounded_random_check word_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we_i),
    .seed_wdata_i (seed_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .bound_i      (bound_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .low_word_o   (low_word_o),
    .high_word_o  (high_word_o),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .checked_count(checked_count),
    .redraw_count (redraw_count)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [1:0] pick_kind();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 7) return KIND_RAW;
    if (r < 14) return KIND_BOUNDED;
    if (r < 19) return KIND_ID;
    return KindUnused;
  endfunction

  // zero, small bounds, powers of two and one above each, bounds at or above 2^63
  // where up to half of all draws are rejected, bounds near 2^64 and random ones
  function automatic logic [WordW-1:0] pick_bound();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WordW'($urandom_range(1, 16));
      2:       return WordW'(1) << $urandom_range(0, WordW - 1);
      3:       return (WordW'(1) << $urandom_range(0, WordW - 1)) + WordW'(1);
      4:       return {1'b1, 31'($urandom), $urandom};
      5:       return AllOnes - WordW'($urandom_range(0, 3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(input logic [1:0] kind, input logic [WordW-1:0] bound);
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    bound_i    <= bound;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    kind_seen[kind]++;
    @(negedge clk_i);
  endtask

  task automatic send_random();
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    send_word(pick_kind(), pick_bound());
  endtask

  // every request yields a word, so once none is owed the block is idle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic load_seed(input logic [WordW-1:0] value);
    seed_we_i    <= 1'b1;
    seed_wdata_i <= value;
    @(negedge clk_i);
    seed_we_i <= 1'b0;
    seed_loads++;
    @(negedge clk_i);
  endtask

  // result side
  initial begin
    int unsigned run;
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (steady) begin
        out_ready_i <= 1'b1;
        @(negedge clk_i);
      end else begin
        run = $urandom_range(1, 8);
        out_ready_i <= 1'b1;
        repeat (run) @(negedge clk_i);
        gap = pick_gap();
        if (gap != 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [WordW-1:0] zero_draw_seed;
    zero_draw_seed = '0 - Gamma;  // first draw mixes a zero state
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed words from the reset state
    steady = 1'b1;
    send_word(KIND_RAW, '0);
    send_word(KIND_BOUNDED, '0);
    send_word(KIND_BOUNDED, WordW'(1));
    send_word(KIND_BOUNDED, WordW'(2));
    send_word(KIND_BOUNDED, WordW'(3));
    send_word(KIND_BOUNDED, WordW'(1) << 32);
    send_word(KIND_BOUNDED, WordW'(1) << (WordW - 1));
    send_word(KIND_BOUNDED, (WordW'(1) << (WordW - 1)) + WordW'(1));
    send_word(KIND_BOUNDED, AllOnes - WordW'(1));
    send_word(KIND_BOUNDED, AllOnes);
    send_word(KIND_ID, AllOnes);
    send_word(KindUnused, {$urandom, $urandom});
    send_word(KIND_RAW, AllOnes);
    drain();
    load_seed(zero_draw_seed);
    send_word(KIND_RAW, '0);
    drain();
    load_seed(zero_draw_seed);
    send_word(KIND_ID, '0);
    drain();
    load_seed(zero_draw_seed);
    send_word(KIND_BOUNDED, WordW'(10));
    drain();
    load_seed(AllOnes);
    send_word(KIND_RAW, '0);
    send_word(KIND_BOUNDED, AllOnes);
    steady = 1'b0;

    for (int p = 0; p < Phases; p++) begin
      drain();
      case (p)
        0:       load_seed('0);
        1:       load_seed(AllOnes);
        default: load_seed({$urandom, $urandom});
      endcase
      steady = (p == 2);
      if (p == 4) begin
        // results pile up until the block stops taking requests
        hold_req = 1'b1;
        repeat (12) send_word(pick_kind(), pick_bound());
      end
      repeat (RandomItems / Phases) send_random();
    end
    steady = 1'b0;
    drain();
    repeat (20) @(negedge clk_i);

    $display("requests: %0d raw, %0d bounded, %0d identifier, %0d unused kind; %0d seed loads",
             kind_seen[KIND_RAW], kind_seen[KIND_BOUNDED], kind_seen[KIND_ID],
             kind_seen[KindUnused], seed_loads);
    $display("%0d result words compared, %0d rejected bounded draws, %0d mismatches",
             checked_count, redraw_count, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
